/* design/pws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_pkg
// Shared constants, codes, types and small functions of the ten-voice sine
// synthesizer with per-voice ADSR envelope.
// ----------------------------------------------------------------------------
package pws_pkg;

    // voice bank
    localparam int VOICE_COUNT = 10;
    localparam int VOICE_W     = $clog2(VOICE_COUNT);

    // sine table and phase accumulator (phase in Q.8 table entries)
    localparam int          TABLE_SIZE  = 48000;
    localparam int          PHASE_W     = 24;
    localparam logic [25:0] PHASE_MOD   = 26'(TABLE_SIZE * 256);
    localparam logic [25:0] PHASE_MOD2  = 26'(2 * TABLE_SIZE * 256);
    // floor(2^40 / TABLE_SIZE), turns index into Q.16 turns
    localparam logic [31:0] INDEX_RECIP = 32'((64'd1 << 40) / TABLE_SIZE);
    localparam int          INDEX_SHIFT = 40;

    // sine polynomial coefficients
    localparam logic [31:0] SIN_A     = 32'd51472;
    localparam logic [31:0] SIN_B     = 32'd21024;
    localparam logic [31:0] SIN_C     = 32'd2320;
    localparam logic [31:0] AMP_SCALE = 32'd32767;
    localparam logic [31:0] AMP_ROUND = 32'd16384;

    // divide by ten of a 32-bit value: (x * recip) >> 35
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

    // sustain scaling: floor(x / 100) by reciprocal floor(2^32 / 100)
    localparam logic [31:0] PCT_RECIP = 32'((64'd1 << 32) / 100);
    localparam logic [6:0]  PCT_MAX   = 7'd100;

    // register reset values and the slopes that follow from them
    localparam logic [6:0]  RST_SUSTAIN = 7'd50;
    localparam logic [15:0] RST_TIME    = 16'd2000;
    localparam logic [15:0] RST_LEVEL   = 16'(50 * 32768 / 100);
    localparam logic [31:0] RST_ATK_SLOPE = 32'((64'd1 << 31) / 2000);
    localparam logic [31:0] RST_DEC_SLOPE = 32'(((64'd32768 - 64'(RST_LEVEL)) << 16) / 2000);
    localparam logic [31:0] RST_REL_SLOPE = 32'((64'(RST_LEVEL) << 16) / 2000);

    localparam logic [16:0] FULL_SCALE = 17'd32768;

    // register indexes
    localparam logic [1:0] REG_SUSTAIN = 2'd0;
    localparam logic [1:0] REG_ATTACK  = 2'd1;
    localparam logic [1:0] REG_DECAY   = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    // input op codes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    // envelope stages
    typedef enum logic [2:0] {
        VS_OFF, VS_ATTACK, VS_DECAY, VS_SUSTAIN, VS_RELEASE
    } voice_stage_t;

    // steps of the per-voice tick sequence
    typedef enum logic [3:0] {
        K_IDX_MUL,
        K_IDX_BACK,
        K_IDX_FIX,
        K_Z_SQ,
        K_POLY_C,
        K_POLY_B,
        K_POLY_A,
        K_AMP_MUL,
        K_GAIN_MUL,
        K_GAIN_SEL,
        K_SCALE_MUL,
        K_DIV10_MUL,
        K_ACCUM
    } calc_step_t;

    // envelope settings handed to the datapath
    typedef struct packed {
        logic [15:0] level;
        logic [31:0] atk_slope;
        logic [31:0] dec_slope;
        logic [31:0] rel_slope;
        logic [15:0] atk_time;
        logic [15:0] dec_time;
        logic [15:0] rel_time;
    } env_cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               note_on;
        logic               note_off;
        logic               tick;
        logic               finish;
        logic [VOICE_W-1:0] voice;
        calc_step_t         step;
    } ctrl_cmd_t;

    // Q.8 phase step of the lowest octave
    function automatic logic [12:0] semitone_step(input logic [3:0] semi);
        logic [12:0] s;
        case (semi)
            4'd0:    s = 13'd4186;
            4'd1:    s = 13'd4434;
            4'd2:    s = 13'd4698;
            4'd3:    s = 13'd4979;
            4'd4:    s = 13'd5274;
            4'd5:    s = 13'd5588;
            4'd6:    s = 13'd5919;
            4'd7:    s = 13'd6272;
            4'd8:    s = 13'd6646;
            4'd9:    s = 13'd7040;
            4'd10:   s = 13'd7460;
            4'd11:   s = 13'd7903;
            default: s = 13'd0;
        endcase
        return s;
    endfunction

    // zero stage time acts as one
    function automatic logic [15:0] eff_time(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

endpackage

/* design/pws_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_cfg
// APB register file and envelope slope unit: each write recomputes the sustain
// level by reciprocal multiply and the three slopes with a serial divider.
// ----------------------------------------------------------------------------
module pws_cfg
    import pws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output env_cfg_t    cfg,
    output logic        busy
);

    typedef enum logic [1:0] {C_IDLE, C_SCALE, C_FIX, C_DIV} cstate_t;

    cstate_t     state_reg;
    logic [6:0]  sus_reg;
    logic [15:0] atk_reg;
    logic [15:0] dec_reg;
    logic [15:0] rel_reg;
    logic [15:0] level_reg;
    logic [31:0] atk_slope_reg;
    logic [31:0] dec_slope_reg;
    logic [31:0] rel_slope_reg;
    logic [47:0] prod_reg;
    logic [1:0]  slot_reg;
    logic [4:0]  bit_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;

    logic        wr;
    logic [1:0]  idx;
    logic [6:0]  pct;
    logic [21:0] pct_x;
    logic [15:0] lvl_q0;
    logic [21:0] lvl_r;
    logic [15:0] level_next;
    logic [15:0] divisor;
    logic [16:0] rem_sh;
    logic        ge;
    logic [15:0] rem_next;
    logic [31:0] quo_next;
    logic [16:0] dec_span;

    assign pready = 1'b1;
    assign busy   = (state_reg != C_IDLE);
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    // read mux
    always_comb
    begin
        case (idx)
            REG_SUSTAIN: prdata = {25'd0, sus_reg};
            REG_ATTACK:  prdata = {16'd0, atk_reg};
            REG_DECAY:   prdata = {16'd0, dec_reg};
            REG_RELEASE: prdata = {16'd0, rel_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // sustain level = floor(pct * 32768 / 100)
    assign pct        = (sus_reg > PCT_MAX) ? PCT_MAX : sus_reg;
    assign pct_x      = {pct, 15'd0};
    assign lvl_q0     = prod_reg[47:32];
    assign lvl_r      = pct_x - 22'(lvl_q0 * 22'd100);
    assign level_next = (lvl_r >= 22'd100) ? lvl_q0 + 16'd1 : lvl_q0;
    assign dec_span   = FULL_SCALE - {1'b0, level_reg};

    // one restoring divide step
    always_comb
    begin
        case (slot_reg)
            2'd0:    divisor = eff_time(atk_reg);
            2'd1:    divisor = eff_time(dec_reg);
            default: divisor = eff_time(rel_reg);
        endcase
    end
    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign ge       = rem_sh >= {1'b0, divisor};
    assign rem_next = ge ? 16'(rem_sh - {1'b0, divisor}) : rem_sh[15:0];
    assign quo_next = {quo_reg[30:0], ge};

    // registers and slope sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            sus_reg       <= RST_SUSTAIN;
            atk_reg       <= RST_TIME;
            dec_reg       <= RST_TIME;
            rel_reg       <= RST_TIME;
            level_reg     <= RST_LEVEL;
            atk_slope_reg <= RST_ATK_SLOPE;
            dec_slope_reg <= RST_DEC_SLOPE;
            rel_slope_reg <= RST_REL_SLOPE;
            slot_reg      <= 2'd0;
            bit_reg       <= 5'd0;
        end
        else if (wr)
        begin
            case (idx)
                REG_SUSTAIN: sus_reg <= pwdata[6:0];
                REG_ATTACK:  atk_reg <= pwdata[15:0];
                REG_DECAY:   dec_reg <= pwdata[15:0];
                REG_RELEASE: rel_reg <= pwdata[15:0];
                default:     ;
            endcase
            state_reg <= C_SCALE;
        end
        else
        begin
            case (state_reg)
                C_SCALE:
                begin
                    prod_reg  <= 48'(48'(pct_x) * 48'(PCT_RECIP));
                    state_reg <= C_FIX;
                end
                C_FIX:
                begin
                    level_reg <= level_next;
                    slot_reg  <= 2'd0;
                    bit_reg   <= 5'd0;
                    rem_reg   <= 16'd0;
                    quo_reg   <= 32'h8000_0000;
                    state_reg <= C_DIV;
                end
                C_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd31)
                    begin
                        rem_reg <= 16'd0;
                        case (slot_reg)
                            2'd0:
                            begin
                                atk_slope_reg <= quo_next;
                                quo_reg       <= {dec_span[15:0], 16'd0};
                                slot_reg      <= 2'd1;
                            end
                            2'd1:
                            begin
                                dec_slope_reg <= quo_next;
                                quo_reg       <= {level_reg, 16'd0};
                                slot_reg      <= 2'd2;
                            end
                            default:
                            begin
                                rel_slope_reg <= quo_next;
                                state_reg     <= C_IDLE;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // settings out
    always_comb
    begin
        cfg.level     = level_reg;
        cfg.atk_slope = atk_slope_reg;
        cfg.dec_slope = dec_slope_reg;
        cfg.rel_slope = rel_slope_reg;
        cfg.atk_time  = eff_time(atk_reg);
        cfg.dec_time  = eff_time(dec_reg);
        cfg.rel_time  = eff_time(rel_reg);
    end

    // a write always starts a recompute
    assert property (@(posedge clk) disable iff (!rst_n) wr |=> busy)
        else $error("slope recompute not started after write");
    // the divider never leaves a remainder at or above the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DIV) |-> (rem_reg < divisor))
        else $error("divider remainder out of range");
    // the level never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n) level_reg <= FULL_SCALE[15:0])
        else $error("sustain level above full scale");

endmodule

/* design/pws_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_ctrl
// Controller: accepts words, walks the voices and the tick steps, and holds
// the result word until it is taken.
// ----------------------------------------------------------------------------
module pws_ctrl
    import pws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] op,
    output logic      out_valid,
    input  logic      out_ready,
    input  logic      cfg_busy,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {ST_IDLE, ST_NOTE, ST_TICK, ST_WRAP, ST_OUT} state_t;

    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICE_COUNT - 1);

    state_t             state_reg;
    logic [1:0]         op_reg;
    logic [VOICE_W-1:0] voice_reg;
    calc_step_t         step_reg;
    logic               accept;

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_busy;
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && in_ready;

    // commands to the datapath
    always_comb
    begin
        cmd.load     = accept;
        cmd.note_on  = (state_reg == ST_NOTE) && (op_reg == OP_NOTE_ON);
        cmd.note_off = (state_reg == ST_NOTE) && (op_reg == OP_NOTE_OFF);
        cmd.tick     = (state_reg == ST_TICK);
        cmd.finish   = (state_reg == ST_WRAP);
        cmd.voice    = voice_reg;
        cmd.step     = step_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_TICK;
            voice_reg <= '0;
            step_reg  <= K_IDX_MUL;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op;
                        voice_reg <= '0;
                        step_reg  <= K_IDX_MUL;
                        if (op == OP_TICK)
                            state_reg <= ST_TICK;
                        else if (op == OP_NOTE_ON || op == OP_NOTE_OFF)
                            state_reg <= ST_NOTE;
                    end
                end
                ST_NOTE:
                begin
                    // voice index stays inside the bank after the scan
                    if (voice_reg == LAST_VOICE)
                    begin
                        voice_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        voice_reg <= voice_reg + 1'b1;
                    end
                end
                ST_TICK:
                begin
                    if (step_reg == K_ACCUM)
                    begin
                        step_reg <= K_IDX_MUL;
                        if (voice_reg == LAST_VOICE)
                        begin
                            voice_reg <= '0;
                            state_reg <= ST_WRAP;
                        end
                        else
                        begin
                            voice_reg <= voice_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        step_reg <= calc_step_t'(step_reg + 4'd1);
                    end
                end
                ST_WRAP:
                    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // no new word while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input taken while result pending");
    // slope recompute blocks input
    assert property (@(posedge clk) disable iff (!rst_n) cfg_busy |-> !in_ready)
        else $error("input taken during slope recompute");
    // a result only follows the mix wrap-up
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_WRAP))
        else $error("result raised without wrap-up");

endmodule

/* design/pws_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_dp
// Datapath: voice state, shared 32x32 multiplier, sine evaluation, envelope
// gain, mix accumulator and output saturation.
// ----------------------------------------------------------------------------
module pws_dp
    import pws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [6:0]         key,
    input  env_cfg_t           cfg,
    output logic signed [15:0] mixed_sample
);

    voice_stage_t       stage_reg [VOICE_COUNT];
    logic [6:0]         vkey_reg  [VOICE_COUNT];
    logic [PHASE_W-1:0] phase_reg [VOICE_COUNT];
    logic [PHASE_W-1:0] vstep_reg [VOICE_COUNT];
    logic [16:0]        cnt_reg   [VOICE_COUNT];

    logic [6:0]         key_reg;
    logic               hit_reg;
    logic [63:0]        p_reg;
    logic [15:0]        q0_reg;
    logic [14:0]        z_reg;
    logic [14:0]        z2_reg;
    logic [1:0]         quad_reg;
    logic [15:0]        amp_reg;
    logic [31:0]        gain_reg;
    logic [31:0]        sum_reg;
    logic signed [15:0] mix_reg;

    logic [VOICE_W-1:0] v;
    voice_stage_t       cur_stage;
    logic [16:0]        cur_cnt;
    logic [15:0]        idx;
    logic [31:0]        idx_n;
    logic [31:0]        idx_r;
    logic [15:0]        turns;
    logic [13:0]        zraw;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic [47:0]        d;
    logic [31:0]        gain_next;
    logic [31:0]        quot;
    logic [31:0]        sample;
    logic               active;
    logic [15:0]        limit;
    logic [25:0]        ph_sum;
    logic [PHASE_W-1:0] ph_next;
    logic [3:0]         oct;
    logic [3:0]         semi;
    logic [31:0]        step_wide;
    logic signed [31:0] sum_s;

    assign v         = cmd.voice;
    assign cur_stage = stage_reg[v];
    assign cur_cnt   = cnt_reg[v];

    // table index to Q.16 turns: floor(idx * 65536 / TABLE_SIZE)
    assign idx   = phase_reg[v][PHASE_W-1:8];
    assign idx_n = {idx, 16'd0};
    assign idx_r = idx_n - p_reg[31:0];
    assign turns = (idx_r >= 32'(TABLE_SIZE)) ? q0_reg + 16'd1 : q0_reg;
    assign zraw  = turns[13:0];

    // shared multiplier operands
    always_comb
    begin
        case (cmd.step)
            K_IDX_MUL:   begin mul_a = idx_n;                  mul_b = INDEX_RECIP;       end
            K_IDX_BACK:  begin mul_a = {16'd0, p_reg[55:40]};  mul_b = 32'(TABLE_SIZE);   end
            K_Z_SQ:      begin mul_a = {17'd0, z_reg};         mul_b = {17'd0, z_reg};    end
            K_POLY_C:    begin mul_a = SIN_C;                  mul_b = {17'd0, p_reg[28:14]}; end
            K_POLY_B:    begin mul_a = SIN_B - {14'd0, p_reg[31:14]};
                               mul_b = {17'd0, z2_reg};                                   end
            K_POLY_A:    begin mul_a = SIN_A - {14'd0, p_reg[31:14]};
                               mul_b = {17'd0, z_reg};                                    end
            K_AMP_MUL:   begin mul_a = {14'd0, p_reg[31:14]};  mul_b = AMP_SCALE;         end
            K_GAIN_MUL:
            begin
                mul_a = {15'd0, cur_cnt};
                case (cur_stage)
                    VS_ATTACK:  mul_b = cfg.atk_slope;
                    VS_DECAY:   mul_b = cfg.dec_slope;
                    default:    mul_b = cfg.rel_slope;
                endcase
            end
            K_SCALE_MUL: begin mul_a = gain_reg;               mul_b = {16'd0, amp_reg};  end
            K_DIV10_MUL: begin mul_a = p_reg[46:15];           mul_b = DIV10_RECIP;       end
            default:     begin mul_a = 32'd0;                  mul_b = 32'd0;             end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // envelope gain from count times slope
    assign d = p_reg[63:16];
    always_comb
    begin
        case (cur_stage)
            VS_ATTACK:  gain_next = d[31:0];
            VS_DECAY:   gain_next = (d >= 48'(FULL_SCALE)) ? 32'd0
                                    : 32'(FULL_SCALE) - d[31:0];
            VS_SUSTAIN: gain_next = {16'd0, cfg.level};
            VS_RELEASE: gain_next = (d >= 48'(cfg.level)) ? 32'd0
                                    : {16'd0, cfg.level} - d[31:0];
            default:    gain_next = 32'd0;
        endcase
    end

    // signed voice sample, truncated toward zero
    assign quot   = {3'd0, p_reg[63:35]};
    assign sample = quad_reg[1] ? 32'd0 - quot : quot;
    assign active = (cur_stage != VS_OFF);

    // envelope stage limit
    always_comb
    begin
        case (cur_stage)
            VS_ATTACK: limit = cfg.atk_time;
            VS_DECAY:  limit = cfg.dec_time;
            default:   limit = cfg.rel_time;
        endcase
    end

    // phase advance with wrap
    assign ph_sum  = 26'(phase_reg[v]) + 26'(vstep_reg[v]);
    assign ph_next = (ph_sum >= PHASE_MOD2) ? PHASE_W'(ph_sum - PHASE_MOD2)
                   : (ph_sum >= PHASE_MOD)  ? PHASE_W'(ph_sum - PHASE_MOD)
                   : ph_sum[PHASE_W-1:0];

    // key to phase step: octave = key / 12 via (key * 43) >> 9
    assign oct       = 4'(({7'd0, key_reg} * 14'd43) >> 9);
    assign semi      = 4'(key_reg - 7'(oct * 7'd12));
    assign step_wide = {19'd0, semitone_step(semi)} << oct;

    // saturated mix
    assign sum_s = sum_reg;

    // work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            key_reg <= key;
        if (cmd.tick)
        begin
            p_reg <= prod;
            case (cmd.step)
                K_IDX_BACK: q0_reg <= p_reg[55:40];
                K_IDX_FIX:
                begin
                    quad_reg <= turns[15:14];
                    z_reg    <= turns[14] ? 15'd16384 - {1'b0, zraw} : {1'b0, zraw};
                end
                K_POLY_C:   z2_reg   <= p_reg[28:14];
                K_GAIN_MUL: amp_reg  <= 16'((p_reg + 64'(AMP_ROUND)) >> 15);
                K_GAIN_SEL: gain_reg <= gain_next;
                default:    ;
            endcase
        end
        if (cmd.finish)
        begin
            if (sum_s > 32'sd32767)
                mix_reg <= 16'sh7FFF;
            else if (sum_s < -32'sd32768)
                mix_reg <= -16'sh8000;
            else
                mix_reg <= sum_reg[15:0];
        end
    end

    assign mixed_sample = mix_reg;

    // voice state and mix accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            sum_reg <= 32'd0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                stage_reg[i] <= VS_OFF;
                vkey_reg[i]  <= 7'd0;
                phase_reg[i] <= '0;
                vstep_reg[i] <= '0;
                cnt_reg[i]   <= 17'd0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
                sum_reg <= 32'd0;
            end
            // note on: first idle voice
            if (cmd.note_on && !hit_reg && cur_stage == VS_OFF)
            begin
                hit_reg      <= 1'b1;
                stage_reg[v] <= VS_ATTACK;
                vkey_reg[v]  <= key_reg;
                vstep_reg[v] <= step_wide[PHASE_W-1:0];
                cnt_reg[v]   <= 17'd0;
            end
            // note off: first sounding voice with this key
            if (cmd.note_off && !hit_reg && active && vkey_reg[v] == key_reg)
            begin
                hit_reg <= 1'b1;
                if (cur_stage != VS_RELEASE)
                begin
                    stage_reg[v] <= VS_RELEASE;
                    cnt_reg[v]   <= 17'd0;
                end
            end
            // tick: mix, then advance envelope and phase
            if (cmd.tick && cmd.step == K_ACCUM)
            begin
                if (active)
                    sum_reg <= sum_reg + sample;
                phase_reg[v] <= ph_next;
                if (cur_stage == VS_ATTACK || cur_stage == VS_DECAY
                    || cur_stage == VS_RELEASE)
                begin
                    if (cur_cnt > {1'b0, limit})
                    begin
                        cnt_reg[v] <= 17'd0;
                        case (cur_stage)
                            VS_ATTACK: stage_reg[v] <= VS_DECAY;
                            VS_DECAY:  stage_reg[v] <= VS_SUSTAIN;
                            default:   stage_reg[v] <= VS_OFF;
                        endcase
                    end
                    else
                    begin
                        cnt_reg[v] <= cur_cnt + 17'd1;
                    end
                end
            end
        end
    end

    // only one voice claimed or released per note word
    assert property (@(posedge clk) disable iff (!rst_n)
        (hit_reg && (cmd.note_on || cmd.note_off)) |=> hit_reg)
        else $error("note word matched more than once");
    // a claimed voice starts its attack from zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.note_on && !hit_reg && cur_stage == VS_OFF)
        |=> (stage_reg[$past(v)] == VS_ATTACK && cnt_reg[$past(v)] == 17'd0))
        else $error("note on did not start attack");
    // phase stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        26'(phase_reg[v]) < PHASE_MOD)
        else $error("phase out of range");

endmodule

/* design/polyphonic_adsr_wavetable_synth_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_adsr_wavetable_synth_unit
// Ten-voice sine synthesizer with one ADSR envelope per voice. Note words
// claim or release voices; a tick word mixes all voices into one sample.
//
//   channel   signals                                  direction  role
//   in        in_valid in_ready op key                 in         note on/off, tick
//   out       out_valid out_ready mixed_sample         out        mixed sample
//   cfg       psel penable pwrite paddr pwdata prdata   in/out     envelope registers
//
// A note word is taken, then scanned over the voices, one scan step per voice.
// A tick word runs each voice through 13 steps on the shared 32x32 multiplier;
// the mix is then saturated into the output register, and the result word is
// offered until it is taken. A register write recomputes the level and then
// each slope with a serial divider; in_ready is low meanwhile.
// Reset clears all voices to off and loads the register reset values.
// While a result waits in the output register no new word is taken.
// ----------------------------------------------------------------------------
module polyphonic_adsr_wavetable_synth_unit
    import pws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [6:0]         key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] mixed_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    env_cfg_t  cfg;
    logic      cfg_busy;
    ctrl_cmd_t cmd;

    // register file and slope unit
    pws_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .busy    (cfg_busy)
    );

    // controller
    pws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_busy  (cfg_busy),
        .cmd       (cmd)
    );

    // datapath
    pws_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .key          (key),
        .cfg          (cfg),
        .mixed_sample (mixed_sample)
    );

endmodule

/* verif/polyphonic_adsr_wavetable_synth_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_adsr_wavetable_synth_unit_tb
// Drives note-on, note-off and tick words into the ten-voice synthesizer and
// checks every mixed sample against a cycle-free voice/envelope predictor.
// Runs several register settings, random idling on both channels and one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module polyphonic_adsr_wavetable_synth_unit_tb;
    import pws_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 1500;
    localparam int PHASE_MOD_I    = TABLE_SIZE * 256;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] key;
    } note_word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic [6:0]         key;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] mixed_sample;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    polyphonic_adsr_wavetable_synth_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .key(key),
        .out_valid(out_valid), .out_ready(out_ready), .mixed_sample(mixed_sample),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // semitone phase steps of octave zero, Q.8
    localparam int unsigned SEMI_STEP [12] = '{
        4186, 4434, 4698, 4979, 5274, 5588, 5919, 6272, 6646, 7040, 7460, 7903
    };

    // predictor state
    logic [6:0]   cfg_sustain;
    logic [15:0]  cfg_attack;
    logic [15:0]  cfg_decay;
    logic [15:0]  cfg_release;
    voice_stage_t stage_p [VOICE_COUNT];
    logic [6:0]   key_p   [VOICE_COUNT];
    logic [23:0]  phase_p [VOICE_COUNT];
    logic [23:0]  step_p  [VOICE_COUNT];
    logic [16:0]  count_p [VOICE_COUNT];

    note_word_t         pending_words [$];
    logic signed [15:0] expected_samples [$];
    int                 errors;
    int                 results_seen;
    bit                 idling_on;
    bit                 run_over;

    function automatic longint unsigned stage_time(input logic [15:0] t);
        return (t == 16'd0) ? 64'd1 : 64'(t);
    endfunction

    function automatic longint unsigned hold_gain();
        longint unsigned pct;
        pct = (cfg_sustain > 7'd100) ? 64'd100 : 64'(cfg_sustain);
        return pct * 32768 / 100;
    endfunction

    // sine table entry by quadrant polynomial
    function automatic int sine_entry(input int unsigned idx);
        longint unsigned p;
        int unsigned     q;
        int unsigned     z;
        int unsigned     z2;
        int unsigned     t;
        int unsigned     y;
        int unsigned     amp;
        p   = ((64'(idx) << 16) / TABLE_SIZE) & 64'hFFFF;
        q   = 32'((p >> 14) & 3);
        z   = 32'(p & 64'h3FFF);
        if (q[0])
            z = 16384 - z;
        z2  = (z * z) >> 14;
        t   = (2320 * z2) >> 14;
        t   = 21024 - t;
        t   = (t * z2) >> 14;
        t   = 51472 - t;
        y   = (t * z) >> 14;
        amp = (y * 32767 + 16384) >> 15;
        return q[1] ? -int'(amp) : int'(amp);
    endfunction

    // envelope gain of one voice, Q.15
    function automatic longint unsigned envelope_gain(input int v);
        longint unsigned c;
        longint unsigned lvl;
        longint unsigned d;
        c   = 64'(count_p[v]);
        lvl = hold_gain();
        case (stage_p[v])
            VS_ATTACK:
                return (c * ((64'd1 << 31) / stage_time(cfg_attack))) >> 16;
            VS_DECAY:
            begin
                d = (c * (((64'd32768 - lvl) << 16) / stage_time(cfg_decay))) >> 16;
                return (d >= 32768) ? 64'd0 : 64'd32768 - d;
            end
            VS_SUSTAIN:
                return lvl;
            VS_RELEASE:
            begin
                d = (c * ((lvl << 16) / stage_time(cfg_release))) >> 16;
                return (d >= lvl) ? 64'd0 : lvl - d;
            end
            default:
                return 64'd0;
        endcase
    endfunction

    function automatic void envelope_advance(input int v);
        longint unsigned lim;
        voice_stage_t    nxt;
        case (stage_p[v])
            VS_ATTACK:
            begin
                lim = stage_time(cfg_attack);
                nxt = VS_DECAY;
            end
            VS_DECAY:
            begin
                lim = stage_time(cfg_decay);
                nxt = VS_SUSTAIN;
            end
            VS_RELEASE:
            begin
                lim = stage_time(cfg_release);
                nxt = VS_OFF;
            end
            default:
                return;
        endcase
        if (64'(count_p[v]) > lim)
        begin
            stage_p[v] = nxt;
            count_p[v] = '0;
        end
        else
            count_p[v] = count_p[v] + 17'd1;
    endfunction

    // apply one accepted word to the voice bank, queue the sample of a tick
    function automatic void synth_apply(input logic [1:0] w_op, input logic [6:0] w_key);
        longint sum;
        longint prod;
        int     v;
        sum = 0;
        if (w_op == OP_NOTE_ON)
        begin
            for (v = 0; v < VOICE_COUNT; v++)
            begin
                if (stage_p[v] == VS_OFF)
                begin
                    stage_p[v] = VS_ATTACK;
                    key_p[v]   = w_key;
                    step_p[v]  = 24'(SEMI_STEP[w_key % 12] << (w_key / 12));
                    count_p[v] = '0;
                    break;
                end
            end
        end
        else if (w_op == OP_NOTE_OFF)
        begin
            for (v = 0; v < VOICE_COUNT; v++)
            begin
                if (stage_p[v] != VS_OFF && key_p[v] == w_key)
                begin
                    if (stage_p[v] != VS_RELEASE)
                    begin
                        stage_p[v] = VS_RELEASE;
                        count_p[v] = '0;
                    end
                    break;
                end
            end
        end
        else if (w_op == OP_TICK)
        begin
            for (v = 0; v < VOICE_COUNT; v++)
            begin
                if (stage_p[v] != VS_OFF)
                begin
                    prod = longint'(envelope_gain(v)) * sine_entry(32'(phase_p[v] >> 8));
                    sum  = sum + prod / (64'sd32768 * VOICE_COUNT);
                end
                envelope_advance(v);
                phase_p[v] = 24'((64'(phase_p[v]) + 64'(step_p[v])) % PHASE_MOD_I);
            end
            if (sum > 32767)
                sum = 32767;
            if (sum < -32768)
                sum = -32768;
            expected_samples.push_back(16'(sum));
        end
    endfunction

    function automatic int draw_idle();
        return idling_on ? int'($urandom_range(0, 12)) : 0;
    endfunction

    // input driver
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= OP_TICK;
            key      <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                synth_apply(op, key);
            if (in_valid && !in_ready)
                ;
            else if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_words.size() != 0)
            begin
                note_word_t w;
                w = pending_words.pop_front();
                op       <= w.op;
                key      <= w.key;
                in_valid <= 1'b1;
                in_gap   <= draw_idle();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long output hold-off once the run is under way
    int hold_left;
    bit hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && results_seen >= 100)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // output monitor and stall
    int out_stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            out_stall    <= 0;
            results_seen <= 0;
        end
        else if (out_valid && out_ready)
        begin
            int d;
            d = draw_idle();
            results_seen <= results_seen + 1;
            if (expected_samples.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("unexpected sample word %0d", mixed_sample);
            end
            else
            begin
                logic signed [15:0] want;
                want = expected_samples.pop_front();
                if (want !== mixed_sample)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("mixed_sample mismatch: expected %0d actual %0d",
                                 want, mixed_sample);
                end
            end
            out_stall <= d;
            out_ready <= (d == 0) && (hold_left == 0);
        end
        else
        begin
            if (out_stall != 0)
                out_stall <= out_stall - 1;
            out_ready <= (out_stall <= 1) && (hold_left == 0);
        end
    end

    // watchdog on cycles with no accepted word
    int quiet_cycles;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || run_over)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_SUSTAIN: cfg_sustain = val[6:0];
            REG_ATTACK:  cfg_attack  = val[15:0];
            REG_DECAY:   cfg_decay   = val[15:0];
            default:     cfg_release = val[15:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic envelope_setup(input int sus, input int atk, input int dec, input int rel);
        reg_write(REG_SUSTAIN, 32'(sus));
        reg_write(REG_ATTACK, 32'(atk));
        reg_write(REG_DECAY, 32'(dec));
        reg_write(REG_RELEASE, 32'(rel));
    endtask

    function automatic void push_word(input logic [1:0] w_op, input logic [6:0] w_key);
        note_word_t w;
        w.op  = w_op;
        w.key = w_key;
        pending_words.push_back(w);
    endfunction

    task automatic drain_bank();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random words: mostly ticks, note words over a small key pool, some noise
    task automatic random_phase(input int count);
        logic [6:0] pool [4];
        int         i;
        int         r;
        for (i = 0; i < 4; i++)
            pool[i] = 7'($urandom_range(0, 127));
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                push_word(OP_TICK, 7'($urandom));
            else if (r < 75)
                push_word(OP_NOTE_ON, pool[$urandom_range(0, 3)]);
            else if (r < 90)
                push_word(OP_NOTE_OFF, pool[$urandom_range(0, 3)]);
            else
                push_word(2'($urandom), 7'($urandom));
        end
        drain_bank();
    endtask

    initial
    begin
        int v;
        int p;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        idling_on   = 1'b1;
        run_over    = 1'b0;
        cfg_sustain = 7'd50;
        cfg_attack  = 16'd2000;
        cfg_decay   = 16'd2000;
        cfg_release = 16'd2000;
        for (v = 0; v < VOICE_COUNT; v++)
        begin
            stage_p[v] = VS_OFF;
            key_p[v]   = '0;
            phase_p[v] = '0;
            step_p[v]  = '0;
            count_p[v] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // full sustain, zero times act as one: ten voices in phase overshoot the mix
        envelope_setup(100, 0, 0, 0);
        for (v = 0; v < VOICE_COUNT; v++)
            push_word(OP_NOTE_ON, 7'd98);
        repeat (4) push_word(OP_TICK, 7'd0);
        push_word(OP_NOTE_ON, 7'd5);      // no idle voice
        push_word(OP_NOTE_OFF, 7'd50);    // no matching voice
        push_word(OP_NOTE_OFF, 7'd98);
        push_word(OP_NOTE_OFF, 7'd98);    // already releasing, keeps its count
        push_word(2'd3, 7'h7F);           // unused op
        repeat (4) push_word(OP_TICK, 7'h55);
        push_word(OP_NOTE_ON, 7'd127);
        push_word(OP_NOTE_ON, 7'd0);
        repeat (3) push_word(OP_TICK, 7'h2A);
        push_word(OP_NOTE_OFF, 7'd127);
        repeat (3) push_word(OP_TICK, 7'd0);
        drain_bank();

        // register settings, extremes first
        envelope_setup(50, 2000, 2000, 2000);
        random_phase(200);
        idling_on = 1'b0;
        envelope_setup(127, 65535, 1, 65535);
        random_phase(200);
        idling_on = 1'b1;
        envelope_setup(0, 1, 1, 1);
        random_phase(250);
        for (p = 0; p < 4; p++)
        begin
            idling_on = p[0];
            envelope_setup($urandom_range(0, 127), $urandom_range(0, 30),
                           $urandom_range(0, 30), $urandom_range(0, 30));
            random_phase(250);
        end

        run_over = 1'b1;
        if (errors == 0 && expected_samples.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
design/pws_pkg.sv
design/pws_cfg.sv
design/pws_ctrl.sv
design/pws_dp.sv
design/polyphonic_adsr_wavetable_synth_unit.sv
verif/polyphonic_adsr_wavetable_synth_unit_tb.sv
